@@ rtl/asm_pkg.sv @@
// attention state merge: shared constants and the exp ratio used to build the weight table
// no dependencies
`default_nettype none

package asm_pkg;

   localparam int LSE_WIDTH                 = 16;
   localparam int SPAN_BITS                 = 12;
   localparam int WEIGHT_BITS               = 17;
   localparam int FRAC_BITS                 = 16;
   localparam int DEFAULT_VALUE_WIDTH       = 16;
   localparam int DEFAULT_EXP_TABLE_BITS    = 10;
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(1 << FRAC_BITS);

   // shift and subtract divide, truncating, for tables built at elaboration
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // exp(-16 / 2^table_bits) in q0.32 from a truncated taylor series
   function automatic logic [63:0] exp_ratio(input int table_bits);
      logic [63:0] s;
      logic [63:0] term;
      logic [63:0] r;
      s    = 64'd1 << (36 - table_bits);
      term = 64'd1 << 32;
      r    = term;
      for (int n = 1; n <= 12; n++) begin
         term = udiv64((term * s) >> 32, 64'(n));
         if (n[0]) begin
            r = r - term;
         end else begin
            r = r + term;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/attention_state_merge_core.sv @@
// attention state merge: log-sum-exp weighted merge of two partial attention outputs
// depends on asm_pkg for constants and the exp ratio
//
// usage
//   req channel: prefix/suffix log-sum-exp (signed q8.8) and prefix/suffix
//   partial values (signed q4.12), one transaction per element
//   rsp channel: merged value (signed q4.12), one transaction per request
//   pipeline: four register stages, the response is registered in the
//   fourth stage
//   throughput: one transaction per cycle when not stalled; the weight table
//   read is the only memory access, a single registered rom port per item
//   stages: lse difference, weight table read, weight select and two
//   multiplies, sum with rounding and clamp into the output register
//   reset: synchronous, clears all stage valid bits; the table is constant
//   and needs no fill
//   stall: each stage holds while the next one is full and blocked, so a
//   stalled receiver backs the pipe up one stage at a time and req_ready
//   drops only once every stage holds a transaction
`default_nettype none

module attention_state_merge_core #(
   parameter int VALUE_WIDTH    = asm_pkg::DEFAULT_VALUE_WIDTH,
   parameter int EXP_TABLE_BITS = asm_pkg::DEFAULT_EXP_TABLE_BITS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic signed [asm_pkg::LSE_WIDTH-1:0]  req_prefix_logsum,
   input  wire logic signed [asm_pkg::LSE_WIDTH-1:0]  req_suffix_logsum,
   input  wire logic signed [VALUE_WIDTH-1:0]         req_prefix_value,
   input  wire logic signed [VALUE_WIDTH-1:0]         req_suffix_value,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [VALUE_WIDTH-1:0]              rsp_merged_value
);
   import asm_pkg::*;

   localparam int TableSize = 1 << EXP_TABLE_BITS;
   localparam int ProdWidth = VALUE_WIDTH + WEIGHT_BITS + 1;
   localparam int AccWidth  = ProdWidth + 1;
   localparam int ResWidth  = AccWidth - FRAC_BITS;

   typedef logic [2*WEIGHT_BITS-1:0] rom_type [TableSize];

   // each entry: weight of the larger side, weight of the smaller side
   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] r;
      logic [63:0] t;
      logic [63:0] e;
      logic [63:0] sum;
      logic [63:0] wbig;
      logic [63:0] wsml;
      r = exp_ratio(EXP_TABLE_BITS);
      t = 64'd1 << 32;
      for (int k = 0; k < TableSize; k++) begin
         if (k > 0) begin
            t = (t * r + (64'd1 << 31)) >> 32;
         end
         e      = (t + 64'd32768) >> 16;
         sum    = 64'd65536 + e;
         wbig   = udiv64((64'd65536 << 16) + (sum >> 1), sum);
         wsml   = udiv64((e << 16) + (sum >> 1), sum);
         rom[k] = {wbig[WEIGHT_BITS-1:0], wsml[WEIGHT_BITS-1:0]};
      end
      return rom;
   endfunction

   localparam rom_type ExpWeightRom = build_rom();

   localparam logic signed [ResWidth-1:0] ResMax = ResWidth'((64'sd1 <<< (VALUE_WIDTH - 1)) - 1);
   localparam logic signed [ResWidth-1:0] ResMin = ResWidth'(-(64'sd1 <<< (VALUE_WIDTH - 1)));

   logic en1, en2, en3, en4;

   // stage 1: lse difference
   logic                            s1_valid_ff;
   logic                            s1_ge_ff;
   logic                            s1_range_ff;
   logic [SPAN_BITS-1:0]            s1_diff_ff;
   logic signed [VALUE_WIDTH-1:0]   s1_pv_ff, s1_sv_ff;
   logic signed [LSE_WIDTH:0]       s1_delta_in;
   logic [LSE_WIDTH-1:0]            s1_abs_in;

   // stage 2: weight table read
   logic                            s2_valid_ff;
   logic                            s2_ge_ff;
   logic                            s2_range_ff;
   logic [WEIGHT_BITS-1:0]          s2_wbig_ff, s2_wsml_ff;
   logic signed [VALUE_WIDTH-1:0]   s2_pv_ff, s2_sv_ff;
   logic [SPAN_BITS+EXP_TABLE_BITS-1:0] idx_wide;
   logic [EXP_TABLE_BITS-1:0]       rom_idx;

   // stage 3: products
   logic                            s3_valid_ff;
   logic signed [ProdWidth-1:0]     s3_pprod_ff, s3_sprod_ff;
   logic [WEIGHT_BITS-1:0]          s3_wp_in, s3_ws_in;

   // stage 4: sum, round, clamp
   logic                            s4_valid_ff;
   logic signed [VALUE_WIDTH-1:0]   s4_merged_ff;
   logic signed [AccWidth-1:0]      s4_acc_in;
   logic signed [ResWidth-1:0]      s4_res_in;
   logic signed [VALUE_WIDTH-1:0]   s4_merged_in;

   assign en4       = !s4_valid_ff || rsp_ready;
   assign en3       = !s3_valid_ff || en4;
   assign en2       = !s2_valid_ff || en3;
   assign en1       = !s1_valid_ff || en2;
   assign req_ready = en1;

   assign s1_delta_in = {req_prefix_logsum[LSE_WIDTH-1], req_prefix_logsum}
                        - {req_suffix_logsum[LSE_WIDTH-1], req_suffix_logsum};
   assign s1_abs_in   = s1_delta_in[LSE_WIDTH] ? LSE_WIDTH'(-s1_delta_in)
                                               : s1_delta_in[LSE_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en1) begin
         s1_valid_ff <= req_valid;
      end
      if (en1) begin
         s1_ge_ff    <= !s1_delta_in[LSE_WIDTH];
         s1_range_ff <= (s1_abs_in[LSE_WIDTH-1:SPAN_BITS] == '0);
         s1_diff_ff  <= s1_abs_in[SPAN_BITS-1:0];
         s1_pv_ff    <= req_prefix_value;
         s1_sv_ff    <= req_suffix_value;
      end
   end

   assign idx_wide = {s1_diff_ff, {EXP_TABLE_BITS{1'b0}}};
   assign rom_idx  = idx_wide[SPAN_BITS+EXP_TABLE_BITS-1:SPAN_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en2) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en2) begin
         {s2_wbig_ff, s2_wsml_ff} <= ExpWeightRom[rom_idx];
         s2_ge_ff    <= s1_ge_ff;
         s2_range_ff <= s1_range_ff;
         s2_pv_ff    <= s1_pv_ff;
         s2_sv_ff    <= s1_sv_ff;
      end
   end

   always_comb begin
      if (!s2_range_ff) begin
         s3_wp_in = s2_ge_ff ? WEIGHT_ONE : '0;
      end else if (s2_ge_ff) begin
         s3_wp_in = s2_wbig_ff;
      end else begin
         s3_wp_in = s2_wsml_ff;
      end
      s3_ws_in = WEIGHT_ONE - s3_wp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en3) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (en3) begin
         s3_pprod_ff <= $signed({1'b0, s3_wp_in}) * s2_pv_ff;
         s3_sprod_ff <= $signed({1'b0, s3_ws_in}) * s2_sv_ff;
      end
   end

   always_comb begin
      s4_acc_in = AccWidth'(s3_pprod_ff) + AccWidth'(s3_sprod_ff)
                  + AccWidth'(1 << (FRAC_BITS - 1));
      s4_res_in = s4_acc_in[AccWidth-1:FRAC_BITS];
      if (s4_res_in > ResMax) begin
         s4_merged_in = ResMax[VALUE_WIDTH-1:0];
      end else if (s4_res_in < ResMin) begin
         s4_merged_in = ResMin[VALUE_WIDTH-1:0];
      end else begin
         s4_merged_in = s4_res_in[VALUE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en4) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (en4) begin
         s4_merged_ff <= s4_merged_in;
      end
   end

   assign rsp_valid        = s4_valid_ff;
   assign rsp_merged_value = s4_merged_ff;

endmodule

`default_nettype wire
